// File: hw/rtl/frwl_pkg.sv
package frwl_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int ID_W     = 4;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   // request codes
   localparam logic [OP_W-1:0] REQ_TRY_SHARED  = 3'd0;
   localparam logic [OP_W-1:0] REQ_SHARED      = 3'd1;
   localparam logic [OP_W-1:0] REQ_EXCL        = 3'd2;
   localparam logic [OP_W-1:0] REQ_REL_SHARED  = 3'd3;
   localparam logic [OP_W-1:0] REQ_REL_EXCL    = 3'd4;
   localparam logic [OP_W-1:0] REQ_CANCEL      = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_GRANT  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CANCEL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd3;

   // one waiting requester
   typedef struct packed {
      logic            excl;
      logic [ID_W-1:0] id;
   } entry_type;

   // sequencer to result buffer
   typedef struct packed {
      logic                valid;
      logic                fin;
      logic [ID_W-1:0]     id;
      logic [STATUS_W-1:0] status;
   } emit_type;

endpackage

// File: hw/rtl/frwl_queue_ram.sv
module frwl_queue_ram #(
   parameter int DEPTH = frwl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  frwl_pkg::entry_type      wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output frwl_pkg::entry_type      rd_data
);

   frwl_pkg::entry_type mem_ff [DEPTH];
   frwl_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/frwl_rsp_buf.sv
module frwl_rsp_buf (
   input  logic                               clock,
   input  logic                               reset,
   input  frwl_pkg::emit_type                 em,
   output logic                               em_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [frwl_pkg::ID_W-1:0]          rsp_grantee,
   output logic [frwl_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_last
);

   // the newest result waits in hold until it is known whether another follows
   logic                          hold_v_ff, hold_v_in;
   logic [frwl_pkg::ID_W-1:0]     hold_id_ff, hold_id_in;
   logic [frwl_pkg::STATUS_W-1:0] hold_st_ff, hold_st_in;
   logic                          out_v_ff, out_v_in;
   logic [frwl_pkg::ID_W-1:0]     out_id_ff, out_id_in;
   logic [frwl_pkg::STATUS_W-1:0] out_st_ff, out_st_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_free;

   assign out_free = !out_v_ff || rsp_ready;
   assign em_ready = !hold_v_ff || out_free;

   always_comb begin
      hold_v_in   = hold_v_ff;
      hold_id_in  = hold_id_ff;
      hold_st_in  = hold_st_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_id_in   = out_id_ff;
      out_st_in   = out_st_ff;
      out_last_in = out_last_ff;
      if (em.valid && em_ready) begin
         if (hold_v_ff) begin
            out_v_in    = 1'b1;
            out_id_in   = hold_id_ff;
            out_st_in   = hold_st_ff;
            out_last_in = 1'b0;
         end
         hold_v_in  = 1'b1;
         hold_id_in = em.id;
         hold_st_in = em.status;
      end else if (em.fin && em_ready && hold_v_ff) begin
         out_v_in    = 1'b1;
         out_id_in   = hold_id_ff;
         out_st_in   = hold_st_ff;
         out_last_in = 1'b1;
         hold_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_id_ff  <= hold_id_in;
      hold_st_ff  <= hold_st_in;
      out_id_ff   <= out_id_in;
      out_st_ff   <= out_st_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_grantee = out_id_ff;
   assign rsp_status  = out_st_ff;
   assign rsp_last    = out_last_ff;

endmodule

// File: hw/rtl/frwl_ctrl.sv
module frwl_ctrl #(
   parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
   parameter int COUNT_WIDTH = frwl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [frwl_pkg::OP_W-1:0]      req_type,
   input  logic [frwl_pkg::ID_W-1:0]      req_requester,
   output frwl_pkg::emit_type             em,
   input  logic                           em_ready,
   output logic                           wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   output frwl_pkg::entry_type            wr_data,
   output logic                           rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   input  frwl_pkg::entry_type            rd_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_HO, S_FIRST, S_RUN, S_SCAN, S_SHIFT, S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [frwl_pkg::OP_W-1:0]     op_ff, op_in;
   logic [frwl_pkg::ID_W-1:0]     id_ff, id_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          excl_ff, excl_in;
   logic                          dw_ff, dw_in;
   logic [frwl_pkg::ID_W-1:0]     dw_id_ff, dw_id_in;
   logic [PTR_W-1:0]              head_ff, head_in;
   logic [PTR_W-1:0]              tail_ff, tail_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [FILL_W-1:0]             idx_ff, idx_in;

   logic                          em_v;
   logic                          em_fin;
   logic [frwl_pkg::ID_W-1:0]     em_id;
   logic [frwl_pkg::STATUS_W-1:0] em_st;
   logic [COUNT_WIDTH-1:0]        cnt_inc1, cnt_inc2, cnt_dec;
   logic                          cnt_zero;
   logic [FILL_W-1:0]             fill_dec;
   logic [PTR_W-1:0]              ptr_nx, ptr_nx2, head_nx;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   assign cnt_inc1 = sat_inc(count_ff);
   assign cnt_inc2 = sat_inc(cnt_inc1);
   assign cnt_dec  = count_ff - 1'b1;
   assign cnt_zero = (count_ff == '0);
   assign fill_dec = fill_ff - 1'b1;
   assign ptr_nx   = ptr_inc(ptr_ff);
   assign ptr_nx2  = ptr_inc(ptr_nx);
   assign head_nx  = ptr_inc(head_ff);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      id_in    = id_ff;
      count_in = count_ff;
      excl_in  = excl_ff;
      dw_in    = dw_ff;
      dw_id_in = dw_id_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      ptr_in   = ptr_ff;
      idx_in   = idx_ff;
      em_v     = 1'b0;
      em_fin   = 1'b0;
      em_id    = id_ff;
      em_st    = frwl_pkg::ST_GRANT;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      wr_data  = '{excl: (op_ff == frwl_pkg::REQ_EXCL), id: id_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_type;
               id_in    = req_requester;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            case (op_ff)
               frwl_pkg::REQ_TRY_SHARED: begin
                  em_v = 1'b1;
                  if (excl_ff) begin
                     em_st = frwl_pkg::ST_REFUSE;
                  end else begin
                     count_in = cnt_inc1;
                  end
               end
               frwl_pkg::REQ_SHARED, frwl_pkg::REQ_EXCL: begin
                  if (excl_ff) begin
                     if (fill_ff >= FILL_W'(QUEUE_DEPTH)) begin
                        em_v  = 1'b1;
                        em_st = frwl_pkg::ST_ERROR;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = ptr_inc(tail_ff);
                        fill_in = fill_ff + 1'b1;
                     end
                  end else if (op_ff == frwl_pkg::REQ_SHARED) begin
                     em_v = 1'b1;
                     if (cnt_zero || dw_ff || fill_ff != '0) begin
                        em_st = frwl_pkg::ST_ERROR;
                     end else begin
                        count_in = cnt_inc1;
                     end
                  end else if (cnt_zero || dw_ff) begin
                     em_v  = 1'b1;
                     em_st = frwl_pkg::ST_ERROR;
                  end else begin
                     excl_in  = 1'b1;
                     dw_id_in = id_ff;
                     count_in = cnt_dec;
                     // no readers left: the writer is granted at once
                     if (cnt_dec == '0) begin
                        em_v  = 1'b1;
                        dw_in = 1'b0;
                     end else begin
                        dw_in = 1'b1;
                     end
                  end
               end
               frwl_pkg::REQ_REL_SHARED: begin
                  if (cnt_zero) begin
                     em_v  = 1'b1;
                     em_st = frwl_pkg::ST_ERROR;
                  end else begin
                     count_in = cnt_dec;
                     if (cnt_dec == '0 && dw_ff) begin
                        em_v  = 1'b1;
                        em_id = dw_id_ff;
                        dw_in = 1'b0;
                     end
                  end
               end
               frwl_pkg::REQ_REL_EXCL: begin
                  if (dw_ff || !excl_ff) begin
                     em_v  = 1'b1;
                     em_st = frwl_pkg::ST_ERROR;
                  end else begin
                     state_in = S_HO;
                  end
               end
               frwl_pkg::REQ_CANCEL: begin
                  if (dw_ff && dw_id_ff == id_ff) begin
                     em_v     = 1'b1;
                     em_st    = frwl_pkg::ST_CANCEL;
                     dw_in    = 1'b0;
                     state_in = excl_ff ? S_HO : S_DONE;
                  end else if (fill_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     ptr_in   = head_ff;
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  em_v  = 1'b1;
                  em_st = frwl_pkg::ST_ERROR;
               end
            endcase
         end

         // hand-over after release exclusive, or after cancel of the drain waiter while exclusive
         S_HO: begin
            if (fill_ff == '0) begin
               count_in = cnt_inc1;
               excl_in  = 1'b0;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_FIRST;
            end
         end

         S_FIRST: begin
            head_in = head_nx;
            fill_in = fill_dec;
            em_v    = 1'b1;
            em_id   = rd_data.id;
            if (rd_data.excl) begin
               state_in = S_DONE;
            end else begin
               // exclusive bias returned plus this reader
               count_in = cnt_inc2;
               if (fill_dec == '0) begin
                  excl_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = head_nx;
                  state_in = S_RUN;
               end
            end
         end

         // batch of queued readers, up to the next writer
         S_RUN: begin
            head_in = head_nx;
            fill_in = fill_dec;
            em_id   = rd_data.id;
            if (rd_data.excl) begin
               dw_id_in = rd_data.id;
               count_in = cnt_dec;
               state_in = S_DONE;
               if (cnt_dec == '0) begin
                  em_v  = 1'b1;
                  dw_in = 1'b0;
               end else begin
                  dw_in = 1'b1;
               end
            end else begin
               em_v     = 1'b1;
               count_in = cnt_inc1;
               if (fill_dec == '0) begin
                  excl_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = head_nx;
               end
            end
         end

         S_SCAN: begin
            if (rd_data.id == id_ff) begin
               em_v    = 1'b1;
               em_st   = frwl_pkg::ST_CANCEL;
               fill_in = fill_dec;
               tail_in = ptr_dec(tail_ff);
               if (idx_ff + 1'b1 == fill_ff) begin
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = ptr_nx;
                  state_in = S_SHIFT;
               end
            end else if (idx_ff + 1'b1 == fill_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               ptr_in  = ptr_nx;
               rd_en   = 1'b1;
               rd_addr = ptr_nx;
            end
         end

         // close the gap: each later entry moves one place towards the head
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data;
            ptr_in  = ptr_nx;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == fill_ff) begin
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_nx2;
            end
         end

         S_DONE: begin
            em_fin   = 1'b1;
            state_in = em_ready ? S_IDLE : S_DONE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result buffer full: hold everything, retry next cycle
      if (em_v && !em_ready) begin
         state_in = state_ff;
         op_in    = op_ff;
         id_in    = id_ff;
         count_in = count_ff;
         excl_in  = excl_ff;
         dw_in    = dw_ff;
         dw_id_in = dw_id_ff;
         head_in  = head_ff;
         tail_in  = tail_ff;
         fill_in  = fill_ff;
         ptr_in   = ptr_ff;
         idx_in   = idx_ff;
         rd_en    = 1'b0;
         wr_en    = 1'b0;
      end
   end

   assign em = '{valid: em_v, fin: em_fin, id: em_id, status: em_st};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= COUNT_WIDTH'(1);
         excl_ff  <= 1'b0;
         dw_ff    <= 1'b0;
         dw_id_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         excl_ff  <= excl_in;
         dw_ff    <= dw_in;
         dw_id_ff <= dw_id_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
      op_ff  <= op_in;
      id_ff  <= id_in;
      ptr_ff <= ptr_in;
      idx_ff <= idx_in;
   end

endmodule

// File: hw/rtl/fifo_reader_writer_lock.sv
// Path: a request is registered and executed, its result waits in the hold register and moves to
// the output register once the next result or the end of the request is known; a hand-over or a
// queue search puts the first result later. One request at a time: a new request is taken only
// once the last is done; a hand-over (release exclusive, or cancel of the drain waiter) pops queued
// entries one by one, a cancel search scans and moves entries up one by one; a stalled output holds it.
// Reset: synchronous; shared count to 1, flags, head and tail pointers and fill to 0; queue memory uncleared.
module fifo_reader_writer_lock #(
   parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
   parameter int COUNT_WIDTH = frwl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [frwl_pkg::OP_W-1:0]     req_type,
   input  logic [frwl_pkg::ID_W-1:0]     req_requester,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [frwl_pkg::ID_W-1:0]     rsp_grantee,
   output logic [frwl_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   frwl_pkg::emit_type  em;
   logic                em_ready;
   logic                wr_en, rd_en;
   logic [PTR_W-1:0]    wr_addr, rd_addr;
   frwl_pkg::entry_type wr_data, rd_data;

   frwl_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_requester(req_requester),
      .em           (em),
      .em_ready     (em_ready),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   frwl_queue_ram #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   frwl_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .em         (em),
      .em_ready   (em_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_grantee(rsp_grantee),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule

// File: hw/rtl/frwl_checker.sv
module frwl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [frwl_pkg::OP_W-1:0]     req_type,
   input logic [frwl_pkg::ID_W-1:0]     req_requester,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [frwl_pkg::ID_W-1:0]     rsp_grantee,
   input logic [frwl_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_last
);

   // a waiting request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type) && $stable(req_requester))
      else $error("request changed while waiting");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grantee)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // refusals and errors are always the only result of their request
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == frwl_pkg::ST_REFUSE || rsp_status == frwl_pkg::ST_ERROR)
         |-> rsp_last)
      else $error("refusal or error not marked last");

   // while a request still has results to come, no new request is taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before previous results complete");

   // one request at a time
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back request transfer");

endmodule

bind fifo_reader_writer_lock frwl_checker u_frwl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_type     (req_type),
   .req_requester(req_requester),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_grantee  (rsp_grantee),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);
